[rtl/lac_pkg.sv]
// shared types, codes and label helpers for the label access check block
package lac_pkg;

	localparam int LABEL_W         = 64;
	localparam int ACC_W           = 3;
	localparam int IDX_W           = 4;
	localparam int CNT_W           = 8;
	localparam int OP_W            = 2;
	localparam int VERDICT_W       = 2;
	localparam int MAX_RULES_DEF   = 16;
	localparam int LABEL_BYTES_DEF = 8;

	// opcodes
	localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_OK    = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_DENY  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_RANGE = 2'd2;

	// access bit positions
	localparam int ACC_WRITE_BIT = 1;

	// special one-character labels
	localparam logic [LABEL_W-1:0] LBL_FLOOR = 64'h5F;
	localparam logic [LABEL_W-1:0] LBL_STAR  = 64'h2A;
	localparam logic [LABEL_W-1:0] LBL_HAT   = 64'h5E;

	// query word walking down the rule chain
	typedef struct packed {
		logic               valid;
		logic               done;
		logic               deny;
		logic [LABEL_W-1:0] subj;
		logic [LABEL_W-1:0] obj;
		logic [ACC_W-1:0]   acc;
	} tok_t;

	// rule write broadcast to every cell
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [LABEL_W-1:0] subj;
		logic [LABEL_W-1:0] obj;
		logic [ACC_W-1:0]   grant;
	} wr_t;

	// label ends at first zero byte, only the low nbytes bytes count
	function automatic logic [LABEL_W-1:0] norm_label(input logic [LABEL_W-1:0] v,
		input int nbytes);
		logic [LABEL_W-1:0] r;
		logic               live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (i >= nbytes || v[8*i +: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				r[8*i +: 8] = v[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

[rtl/lac_cell.sv]
// one rule slot of the chain: holds a rule and checks the passing query word
module lac_cell #(
	parameter int CELL_IDX = 0,
	parameter int CW       = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lac_pkg::wr_t  wr,
	input  logic [CW-1:0] active_rules,
	input  lac_pkg::tok_t tok_in,
	output lac_pkg::tok_t tok_out
);

	localparam int IW = lac_pkg::IDX_W;
	localparam bit WR_REACH = CELL_IDX < (1 << IW);
	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);
	localparam logic [CW-1:0] MY_POS = CW'(CELL_IDX);

	logic [lac_pkg::LABEL_W-1:0] subj_q;
	logic [lac_pkg::LABEL_W-1:0] obj_q;
	logic [lac_pkg::ACC_W-1:0]   grant_q;
	logic                        hit;
	lac_pkg::tok_t               tok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subj_q  <= '0;
			obj_q   <= '0;
			grant_q <= '0;
		end else if (wr.en && WR_REACH && wr.idx == MY_IDX) begin
			subj_q  <= wr.subj;
			obj_q   <= wr.obj;
			grant_q <= wr.grant;
		end
	end

	// first active matching rule decides
	assign hit = tok_in.valid && !tok_in.done && (MY_POS < active_rules) &&
		subj_q == tok_in.subj && obj_q == tok_in.obj;

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.done = 1'b1;
			tok_d.deny = |(~grant_q & tok_in.acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= tok_d;
		end
	end

endmodule

[rtl/label_access_check.sv]
// top level of the label access check engine: decode, rule chain and result buffer
//
// usage:
// - input channel in_valid / in_ready carries one word per item: a check, a
//   rule write or a rule count update; each item returns exactly one verdict
// - output channel out_valid / out_ready carries the verdict word
// - one item is in flight at a time; in_ready is high while nothing is in flight,
//   even if the previous verdict still sits in the output register
// - a check decided by the fixed label rules goes from accept to out_valid
//   through the decode, pending and output registers; writes and count updates as well
// - a check that needs the rule table walks a chain of MAX_RULES cells, one
//   cell per cycle, between the decode and pending registers; the chain length sets
//   the rate for table lookups
// - with a ready receiver in_ready rises together with out_valid, so the next
//   word can be taken while the verdict is on the output
// - reset clears the rule table, the active count and all valid flags at once
// - when the receiver stalls, the verdict waits in the output register; the
//   next item's verdict waits one stage behind it and holds further input off
module label_access_check #(
	parameter int MAX_RULES   = lac_pkg::MAX_RULES_DEF,
	parameter int LABEL_BYTES = lac_pkg::LABEL_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lac_pkg::OP_W-1:0]        opcode,
	input  logic [lac_pkg::LABEL_W-1:0]     subject_label,
	input  logic [lac_pkg::LABEL_W-1:0]     object_label,
	input  logic [lac_pkg::ACC_W-1:0]       access_wanted,
	input  logic [lac_pkg::IDX_W-1:0]       rule_index,
	input  logic [lac_pkg::ACC_W-1:0]       rule_allowed,
	input  logic [lac_pkg::CNT_W-1:0]       new_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lac_pkg::VERDICT_W-1:0]   verdict
);

	// active count must hold MAX_RULES itself
	localparam int CW = $clog2(MAX_RULES + 1);
	localparam int CMP_W = lac_pkg::CNT_W + 1;

	// in-flight tracking
	logic busy_q;
	logic in_acc;

	// decode stage
	logic                          s1_valid_q;
	logic [lac_pkg::OP_W-1:0]      op_s1;
	logic [lac_pkg::LABEL_W-1:0]   subj_s1;
	logic [lac_pkg::LABEL_W-1:0]   obj_s1;
	logic [lac_pkg::ACC_W-1:0]     acc_s1;
	logic [lac_pkg::IDX_W-1:0]     idx_s1;
	logic [lac_pkg::ACC_W-1:0]     allowed_s1;
	logic [lac_pkg::CNT_W-1:0]     cnt_s1;

	logic [lac_pkg::LABEL_W-1:0]   subj_n;
	logic [lac_pkg::LABEL_W-1:0]   obj_n;
	logic                          read_exec_only;

	logic [CW-1:0]                 active_q;
	logic                          cnt_load;

	lac_pkg::wr_t                  wr;
	lac_pkg::tok_t                 launch;
	lac_pkg::tok_t                 chain [MAX_RULES+1];
	lac_pkg::tok_t                 tail;

	logic                          s1_load;
	logic [lac_pkg::VERDICT_W-1:0] s1_code;

	// pending verdict behind the output register
	logic                          pend_valid_q;
	logic [lac_pkg::VERDICT_W-1:0] pend_code_q;
	logic                          pend_move;

	logic                          out_valid_q;
	logic [lac_pkg::VERDICT_W-1:0] verdict_q;

	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (pend_move) begin
			busy_q <= 1'b0;
		end
	end

	// capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= opcode;
			subj_s1    <= subject_label;
			obj_s1     <= object_label;
			acc_s1     <= access_wanted;
			idx_s1     <= rule_index;
			allowed_s1 <= rule_allowed;
			cnt_s1     <= new_count;
		end
	end

	assign subj_n = lac_pkg::norm_label(subj_s1, LABEL_BYTES);
	assign obj_n  = lac_pkg::norm_label(obj_s1, LABEL_BYTES);
	assign read_exec_only = !acc_s1[lac_pkg::ACC_WRITE_BIT];

	// decode: fixed label rules, rule writes, count update, unused opcode, or launch into the chain
	always_comb begin
		launch   = '0;
		wr       = '0;
		s1_load  = 1'b0;
		s1_code  = lac_pkg::VERDICT_OK;
		cnt_load = 1'b0;
		if (s1_valid_q) begin
			unique case (op_s1)
				lac_pkg::OP_CHECK: begin
					priority if (subj_n == lac_pkg::LBL_STAR) begin
						s1_load = 1'b1;
						s1_code = lac_pkg::VERDICT_DENY;
					end else if (read_exec_only && (subj_n == lac_pkg::LBL_HAT ||
						obj_n == lac_pkg::LBL_FLOOR)) begin
						s1_load = 1'b1;
					end else if (obj_n == lac_pkg::LBL_STAR || subj_n == obj_n) begin
						s1_load = 1'b1;
					end else begin
						launch.valid = 1'b1;
						launch.subj  = subj_n;
						launch.obj   = obj_n;
						launch.acc   = acc_s1;
					end
				end
				lac_pkg::OP_WRITE: begin
					// slots past capacity match no cell
					wr.en    = 1'b1;
					wr.idx   = idx_s1;
					wr.subj  = subj_n;
					wr.obj   = obj_n;
					wr.grant = allowed_s1;
					s1_load  = 1'b1;
				end
				lac_pkg::OP_COUNT: begin
					s1_load = 1'b1;
					if ({1'b0, cnt_s1} > CMP_W'(MAX_RULES)) begin
						s1_code = lac_pkg::VERDICT_RANGE;
					end else begin
						cnt_load = 1'b1;
					end
				end
				default: begin
					s1_load = 1'b1;
				end
			endcase
		end
	end

	assign chain[0] = launch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cnt_load) begin
			active_q <= CW'(cnt_s1);
		end
	end

	// rule chain, one cell per slot
	for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
		lac_cell #(
			.CELL_IDX (g),
			.CW       (CW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.wr           (wr),
			.active_rules (active_q),
			.tok_in       (chain[g]),
			.tok_out      (chain[g+1])
		);
	end

	assign tail = chain[MAX_RULES];

	// no matching rule means deny
	assign pend_move = pend_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (s1_load || tail.valid) begin
			pend_valid_q <= 1'b1;
		end else if (pend_move) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			pend_code_q <= s1_code;
		end else if (tail.valid) begin
			pend_code_q <= (tail.done && !tail.deny) ? lac_pkg::VERDICT_OK :
				lac_pkg::VERDICT_DENY;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			verdict_q <= pend_code_q;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

`ifndef SYNTH
	// only one stage of the item flow holds the word
	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({s1_valid_q, pend_valid_q, tail.valid}) <= 1)
		else $error("more than one stage holds the item");

	// accept only with nothing in flight, then decode next cycle
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid_q && busy_q)
		else $error("accepted word not decoded");

	// active count never exceeds capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(active_q) <= MAX_RULES)
		else $error("active count above capacity");

	// a pending verdict always belongs to an item in flight
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> busy_q)
		else $error("pending verdict with nothing in flight");
`endif

endmodule

[tb/lac_checker.sv]
// checker for label_access_check: watches both channels, predicts and scores verdict words
`timescale 1ns / 1ps

module lac_checker #(
	parameter int MAX_RULES   = lac_pkg::MAX_RULES_DEF,
	parameter int LABEL_BYTES = lac_pkg::LABEL_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [lac_pkg::OP_W-1:0]        opcode,
	input  logic [lac_pkg::LABEL_W-1:0]     subject_label,
	input  logic [lac_pkg::LABEL_W-1:0]     object_label,
	input  logic [lac_pkg::ACC_W-1:0]       access_wanted,
	input  logic [lac_pkg::IDX_W-1:0]       rule_index,
	input  logic [lac_pkg::ACC_W-1:0]       rule_allowed,
	input  logic [lac_pkg::CNT_W-1:0]       new_count,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [lac_pkg::VERDICT_W-1:0]   verdict,
	output int                              fail_count,
	output int                              pending
);

	// shadow copy of the rule table
	logic [lac_pkg::LABEL_W-1:0]   tbl_subj  [MAX_RULES];
	logic [lac_pkg::LABEL_W-1:0]   tbl_obj   [MAX_RULES];
	logic [lac_pkg::ACC_W-1:0]     tbl_grant [MAX_RULES];
	int                            live_rules;

	logic [lac_pkg::VERDICT_W-1:0] verdict_q [$];
	logic [lac_pkg::LABEL_W-1:0]   cur_subj;
	logic [lac_pkg::LABEL_W-1:0]   cur_obj;
	logic [lac_pkg::VERDICT_W-1:0] want_v;
	logic [lac_pkg::VERDICT_W-1:0] exp_v;

	// cut a label at its first zero byte and at LABEL_BYTES
	function automatic logic [lac_pkg::LABEL_W-1:0] trim_label(
		input logic [lac_pkg::LABEL_W-1:0] raw);
		logic [lac_pkg::LABEL_W-1:0] r;
		int                          n;
		r = '0;
		for (n = 0; n < LABEL_BYTES && n < 8; n++) begin
			if (raw[8*n +: 8] == 8'h00) break;
			r[8*n +: 8] = raw[8*n +: 8];
		end
		return r;
	endfunction

	function automatic logic [lac_pkg::VERDICT_W-1:0] decide_access(
		input logic [lac_pkg::LABEL_W-1:0] subj,
		input logic [lac_pkg::LABEL_W-1:0] obj, input logic [lac_pkg::ACC_W-1:0] acc);
		logic no_write;
		no_write = !acc[lac_pkg::ACC_WRITE_BIT];
		if (subj == lac_pkg::LBL_STAR) return lac_pkg::VERDICT_DENY;
		if (subj == lac_pkg::LBL_HAT && no_write) return lac_pkg::VERDICT_OK;
		if (obj == lac_pkg::LBL_FLOOR && no_write) return lac_pkg::VERDICT_OK;
		if (obj == lac_pkg::LBL_STAR) return lac_pkg::VERDICT_OK;
		if (subj == obj) return lac_pkg::VERDICT_OK;
		for (int i = 0; i < live_rules && i < MAX_RULES; i++) begin
			if (tbl_subj[i] == subj && tbl_obj[i] == obj)
				return ((acc & ~tbl_grant[i]) != '0) ? lac_pkg::VERDICT_DENY :
					lac_pkg::VERDICT_OK;
		end
		return lac_pkg::VERDICT_DENY;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RULES; i++) begin
				tbl_subj[i]  = '0;
				tbl_obj[i]   = '0;
				tbl_grant[i] = '0;
			end
			live_rules = 0;
			verdict_q.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready) begin
				cur_subj = trim_label(subject_label);
				cur_obj  = trim_label(object_label);
				want_v   = lac_pkg::VERDICT_OK;
				case (opcode)
					lac_pkg::OP_CHECK: begin
						want_v = decide_access(cur_subj, cur_obj, access_wanted);
					end
					lac_pkg::OP_WRITE: begin
						if (rule_index < MAX_RULES) begin
							tbl_subj[rule_index]  = cur_subj;
							tbl_obj[rule_index]   = cur_obj;
							tbl_grant[rule_index] = rule_allowed;
						end
					end
					lac_pkg::OP_COUNT: begin
						if (new_count > MAX_RULES) want_v = lac_pkg::VERDICT_RANGE;
						else live_rules = int'(new_count);
					end
					default: begin
					end
				endcase
				verdict_q.push_back(want_v);
			end
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$error("verdict: expected none, got %0d", verdict);
					fail_count++;
				end else begin
					exp_v = verdict_q.pop_front();
					if (exp_v !== verdict) begin
						$error("verdict: expected %0d, got %0d", exp_v, verdict);
						fail_count++;
					end
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
// top of the label_access_check testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 1ps

module tb_top;

	// opcode with no function, the block just answers ok
	localparam logic [lac_pkg::OP_W-1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 40;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [lac_pkg::OP_W-1:0]      opcode;
	logic [lac_pkg::LABEL_W-1:0]   subject_label;
	logic [lac_pkg::LABEL_W-1:0]   object_label;
	logic [lac_pkg::ACC_W-1:0]     access_wanted;
	logic [lac_pkg::IDX_W-1:0]     rule_index;
	logic [lac_pkg::ACC_W-1:0]     rule_allowed;
	logic [lac_pkg::CNT_W-1:0]     new_count;
	logic                          out_valid;
	logic                          out_ready;
	logic [lac_pkg::VERDICT_W-1:0] verdict;

	int fail_count;
	int pending_words;
	int cycle_cnt = 0;
	// no_idle forces zero gaps on both sides for a stretch
	bit no_idle = 1'b0;
	// receiver long hold-off is asked by bumping hold_asked
	int hold_asked  = 0;
	int hold_served = 0;
	int rx_stall;

	label_access_check u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.subject_label(subject_label),
		.object_label (object_label),
		.access_wanted(access_wanted),
		.rule_index   (rule_index),
		.rule_allowed (rule_allowed),
		.new_count    (new_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict)
	);

	lac_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.subject_label(subject_label),
		.object_label (object_label),
		.access_wanted(access_wanted),
		.rule_index   (rule_index),
		.rule_allowed (rule_allowed),
		.new_count    (new_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict),
		.fail_count   (fail_count),
		.pending      (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// small set of names so that rules, equal labels and specials keep colliding
	function automatic logic [lac_pkg::LABEL_W-1:0] pool_label(input int k);
		case (k)
			0:       return lac_pkg::LBL_STAR;
			1:       return lac_pkg::LBL_HAT;
			2:       return lac_pkg::LBL_FLOOR;
			3:       return 64'h61;                  // "a"
			4:       return 64'h6261;                // "ab"
			5:       return 64'h73_7265_7375;        // "users"
			6:       return 64'h6867_6665_6463_6261; // "abcdefgh", no terminator
			default: return '0;                      // empty label
		endcase
	endfunction

	// pool name, sometimes with junk past the terminator, or a fully random word
	function automatic logic [lac_pkg::LABEL_W-1:0] pick_label();
		logic [lac_pkg::LABEL_W-1:0] v;
		int                          len;
		int                          k;
		k = $urandom_range(0, 9);
		if (k >= 8) return {$urandom, $urandom};
		v   = pool_label(k);
		len = 0;
		while (len < 8 && v[8*len +: 8] != 8'h00) len++;
		// junk only above the zero byte that ends the label
		if (len < 7 && $urandom_range(0, 2) == 0)
			v = v | ({$urandom, $urandom} << (8 * (len + 1)));
		return v;
	endfunction

	// offer one word, entered and left at a falling edge; valid stays up on return
	task automatic offer_word(input logic [lac_pkg::OP_W-1:0] op,
		input logic [lac_pkg::LABEL_W-1:0] subj,
		input logic [lac_pkg::LABEL_W-1:0] obj, input logic [lac_pkg::ACC_W-1:0] acc,
		input logic [lac_pkg::IDX_W-1:0] idx, input logic [lac_pkg::ACC_W-1:0] grant,
		input logic [lac_pkg::CNT_W-1:0] cnt);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode        <= op;
		subject_label <= subj;
		object_label  <= obj;
		access_wanted <= acc;
		rule_index    <= idx;
		rule_allowed  <= grant;
		new_count     <= cnt;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic random_word();
		int                              r;
		logic [lac_pkg::OP_W-1:0]        op;
		logic [lac_pkg::CNT_W-1:0]       cnt;
		r = $urandom_range(0, 99);
		if (r < 58) op = lac_pkg::OP_CHECK;
		else if (r < 83) op = lac_pkg::OP_WRITE;
		else if (r < 97) op = lac_pkg::OP_COUNT;
		else op = OP_NONE;
		// counts mostly in range so the table stays live, some refused
		if (op == lac_pkg::OP_COUNT)
			cnt = ($urandom_range(0, 3) == 0) ? lac_pkg::CNT_W'($urandom_range(17, 255)) :
				lac_pkg::CNT_W'($urandom_range(0, 16));
		else
			cnt = lac_pkg::CNT_W'($urandom_range(0, 255));
		offer_word(op, pick_label(), pick_label(), lac_pkg::ACC_W'($urandom_range(0, 7)),
			lac_pkg::IDX_W'($urandom_range(0, 15)), lac_pkg::ACC_W'($urandom_range(0, 7)),
			cnt);
	endtask

	// sender stops and lets every verdict drain
	task automatic drain_all();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_words != 0) @(negedge clk);
	endtask

	// receiver: random stall per word, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			rx_stall = no_idle ? 0 : $urandom_range(0, 5);
			if (rx_stall != 0) begin
				out_ready <= 1'b0;
				repeat (rx_stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// stimulus and final verdict
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = lac_pkg::OP_CHECK;
		subject_label = '0;
		object_label  = '0;
		access_wanted = '0;
		rule_index    = '0;
		rule_allowed  = '0;
		new_count     = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: full table count, shadowed rules, junk past terminators
		offer_word(lac_pkg::OP_COUNT, '0, '0, 3'd0, 4'd0, 3'd0, 8'd16);
		offer_word(lac_pkg::OP_WRITE, 64'hDEAD_BEEF_CAFE_0061, 64'h6261, 3'd0, 4'd0,
			3'b101, 8'd0);
		offer_word(lac_pkg::OP_WRITE, 64'h73_7265_7375, 64'h6867_6665_6463_6261, 3'd7,
			4'd15, 3'b111, 8'd255);
		offer_word(lac_pkg::OP_WRITE, 64'h61, 64'h6261, 3'd0, 4'd1, 3'b111, 8'd0);
		// first matching rule decides, later duplicates do not
		offer_word(lac_pkg::OP_CHECK, 64'h61, 64'h6261, 3'b001, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'h61, 64'h6261, 3'b010, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'hFFFF_0061, 64'hFFFF_FF00_6261, 3'b101, 4'd0,
			3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'h73_7265_7375, 64'h6867_6665_6463_6261, 3'd7,
			4'd15, 3'd7, 8'd255);
		// fixed label rules
		offer_word(lac_pkg::OP_CHECK, lac_pkg::LBL_STAR, lac_pkg::LBL_STAR, 3'd0, 4'd0,
			3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, lac_pkg::LBL_HAT, 64'h6261, 3'b101, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, lac_pkg::LBL_HAT, 64'h6261, 3'b010, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'h61, lac_pkg::LBL_FLOOR, 3'b001, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'h61, lac_pkg::LBL_FLOOR, 3'b111, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'h61, lac_pkg::LBL_STAR, 3'b111, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, '1, '1, 3'd7, 4'd15, 3'd7, 8'd255);
		offer_word(lac_pkg::OP_CHECK, '0, '0, 3'd0, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'h6261, 64'h61, 3'b001, 4'd0, 3'd0, 8'd0);
		// count limits: refused above capacity, zero turns the table off
		offer_word(lac_pkg::OP_COUNT, '0, '0, 3'd0, 4'd0, 3'd0, 8'd17);
		offer_word(lac_pkg::OP_COUNT, '1, '1, 3'd7, 4'd15, 3'd7, 8'd255);
		offer_word(lac_pkg::OP_COUNT, '0, '0, 3'd0, 4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_CHECK, 64'h61, 64'h6261, 3'b001, 4'd0, 3'd0, 8'd0);
		offer_word(OP_NONE, '1, '1, 3'd7, 4'd15, 3'd7, 8'd255);
		offer_word(lac_pkg::OP_COUNT, '0, '0, 3'd0, 4'd0, 3'd0, 8'd1);
		// slot 15 is past the active count now
		offer_word(lac_pkg::OP_CHECK, 64'h73_7265_7375, 64'h6867_6665_6463_6261, 3'b001,
			4'd0, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_WRITE, '1, '0, 3'd0, 4'd15, 3'd0, 8'd0);
		offer_word(lac_pkg::OP_COUNT, '0, '0, 3'd0, 4'd0, 3'd0, 8'd16);

		// random traffic in phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// receiver holds off long while words keep coming
			if (i == 400) hold_asked++;
			// sender pauses until every verdict is back
			if (i == 800) drain_all();
			no_idle = (i >= 1000 && i < 1200);
			random_word();
		end

		in_valid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
